// ===== sv/rc5_key_trial_core_assert.svh =====
// Assertion macros shared by the key trial RTL.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef RC5_KEY_TRIAL_CORE_ASSERT_SVH
`define RC5_KEY_TRIAL_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RC5KT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc5 key trial: check failed");

// Next-cycle implication.
`define RC5KT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc5 key trial: check failed");

`else

`define RC5KT_ASSERT_NOW(label, ante, cons)
`define RC5KT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/rc5kt_pkg.sv =====
`timescale 1ns / 1ps

package rc5kt_pkg;

    // Default round count
    localparam int ROUNDS_DEF = 12;

    // Key schedule magic constants
    localparam logic [31:0] MAGIC_P = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

    // Register indexes of the write channel
    typedef enum logic [1:0] {
        REG_PLAIN_LOW   = 2'd0,
        REG_PLAIN_HIGH  = 2'd1,
        REG_CIPHER_LOW  = 2'd2,
        REG_CIPHER_HIGH = 2'd3
    } reg_index_t;

    // Per-step control handed from the schedule engine to the cipher datapath
    typedef struct packed {
        logic load;   // a final subkey is present on the subkey bus
        logic first;  // subkey 0 or 1: whitening add
        logic odd;    // odd subkey index: update B, else update A
        logic last;   // final subkey of the table
    } enc_ctl_t;

    // Left rotate by the low five bits of the amount
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

endpackage

// ===== sv/rc5_key_trial_core.sv =====
`timescale 1ns / 1ps
// An accepted key runs three mixing passes; the cipher result then goes to the result register.
// One item at a time, taken only in idle; the subkey table takes one mixing step a cycle.
// The final pass feeds the cipher one subkey a cycle, each the cycle after it is mixed.
// Reset (rst_n, async, active low) clears control and the four data registers to zero.
// The subkey table needs no clearing: every entry is written before it is read.

`include "rc5_key_trial_core_assert.svh"

module rc5_key_trial_core
    import rc5kt_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // key item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key_low, [63:32] key_high
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] match, [7:1] zero
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        match_reg, match_next;
    logic [31:0] plain_low_reg, plain_high_reg, cipher_low_reg, cipher_high_reg;

    logic        s_accept;
    logic        out_free;
    logic        eval;
    logic        match;
    logic [31:0] sub_bus;
    enc_ctl_t    enc;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Hold the configured blocks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_low_reg   <= '0;
            plain_high_reg  <= '0;
            cipher_low_reg  <= '0;
            cipher_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PLAIN_LOW:   plain_low_reg   <= cfg_data;
                REG_PLAIN_HIGH:  plain_high_reg  <= cfg_data;
                REG_CIPHER_LOW:  cipher_low_reg  <= cfg_data;
                REG_CIPHER_HIGH: cipher_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rc5kt_sched #(
        .ROUNDS (ROUNDS)
    ) u_sched (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_accept),
        .key_low  (s_tdata[31:0]),
        .key_high (s_tdata[63:32]),
        .sub_out  (sub_bus),
        .enc      (enc)
    );

    rc5kt_enc u_enc (
        .clk         (clk),
        .rst_n       (rst_n),
        .enc         (enc),
        .sub_in      (sub_bus),
        .plain_low   (plain_low_reg),
        .plain_high  (plain_high_reg),
        .cipher_low  (cipher_low_reg),
        .cipher_high (cipher_high_reg),
        .eval        (eval),
        .match       (match)
    );

    // Sequence one item and park the result in the output register
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        match_next    = match_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (eval)
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        match_next    = match;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    match_next    = match;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, match_reg};

    `RC5KT_ASSERT_NOW(a_eval_busy, eval, state_reg == ST_BUSY)
    `RC5KT_ASSERT_NEXT(a_accept_busy, s_accept, state_reg == ST_BUSY)
    `RC5KT_ASSERT_NOW(a_hold_full, state_reg == ST_HOLD, m_tvalid_reg)
    `RC5KT_ASSERT_NOW(a_idle_no_load, state_reg == ST_IDLE, !enc.load)

endmodule

// ===== sv/rc5kt_sched.sv =====
`timescale 1ns / 1ps

`include "rc5_key_trial_core_assert.svh"

module rc5kt_sched
    import rc5kt_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] key_low,
    input  logic [31:0] key_high,
    output logic [31:0] sub_out,
    output enc_ctl_t    enc
);

    localparam int NSUB  = 2 * ROUNDS + 2;
    localparam int IDX_W = $clog2(NSUB);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NSUB - 1);
    localparam logic [1:0] PASS_SEED = 2'd0;
    localparam logic [1:0] PASS_LAST = 2'd2;

    // Subkey table
    logic [31:0] sub_mem [NSUB];
    logic [31:0] rdata_reg;

    logic             run_reg,  run_next;
    logic [IDX_W-1:0] idx_reg,  idx_next;
    logic [1:0]       pass_reg, pass_next;
    logic             j_reg,    j_next;
    logic [31:0]      a_reg,    a_next;
    logic [31:0]      b_reg,    b_next;
    logic [31:0]      l0_reg,   l0_next;
    logic [31:0]      l1_reg,   l1_next;
    logic [31:0]      seed_reg, seed_next;
    enc_ctl_t         enc_reg,  enc_next;

    logic [31:0] sub_in;
    logic [31:0] a_new;
    logic [31:0] ab_sum;
    logic [31:0] l_sel;
    logic [31:0] b_new;
    logic        wrap;

    // One mixing step: pass one takes the seeded value, later passes the table
    always_comb
    begin
        sub_in = (pass_reg == PASS_SEED) ? seed_reg : rdata_reg;
        a_new  = rotl32(sub_in + a_reg + b_reg, 5'd3);
        ab_sum = a_new + b_reg;
        l_sel  = j_reg ? l1_reg : l0_reg;
        b_new  = rotl32(l_sel + ab_sum, ab_sum[4:0]);
        wrap   = (idx_reg == IDX_LAST);
    end

    // Advance counters and mixing registers
    always_comb
    begin
        run_next  = run_reg;
        idx_next  = idx_reg;
        pass_next = pass_reg;
        j_next    = j_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        l0_next   = l0_reg;
        l1_next   = l1_reg;
        seed_next = seed_reg;
        enc_next  = '0;
        if (start)
        begin
            run_next  = 1'b1;
            idx_next  = '0;
            pass_next = PASS_SEED;
            j_next    = 1'b0;
            a_next    = '0;
            b_next    = '0;
            l0_next   = key_low;
            l1_next   = key_high;
            seed_next = MAGIC_P;
        end
        else if (run_reg)
        begin
            a_next    = a_new;
            b_next    = b_new;
            j_next    = ~j_reg;
            seed_next = seed_reg + MAGIC_Q;
            if (j_reg)
            begin
                l1_next = b_new;
            end
            else
            begin
                l0_next = b_new;
            end
            idx_next = wrap ? '0 : idx_reg + 1'b1;
            if (wrap)
            begin
                pass_next = pass_reg + 2'd1;
                if (pass_reg == PASS_LAST)
                begin
                    run_next = 1'b0;
                end
            end
            // Final pass: each new subkey feeds the cipher next cycle
            enc_next.load  = (pass_reg == PASS_LAST);
            enc_next.first = (idx_reg < IDX_W'(2));
            enc_next.odd   = idx_reg[0];
            enc_next.last  = wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            idx_reg  <= '0;
            pass_reg <= PASS_SEED;
            j_reg    <= 1'b0;
            enc_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            idx_reg  <= idx_next;
            pass_reg <= pass_next;
            j_reg    <= j_next;
            enc_reg  <= enc_next;
        end
    end

    // Datapath words
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        l0_reg   <= l0_next;
        l1_reg   <= l1_next;
        seed_reg <= seed_next;
    end

    // Write back the mixed subkey, read the one for the next step
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            sub_mem[idx_reg] <= a_new;
            rdata_reg        <= sub_mem[idx_next];
        end
    end

    assign sub_out = a_reg;
    assign enc     = enc_reg;

    `RC5KT_ASSERT_NOW(a_start_idle, start, !run_reg)
    `RC5KT_ASSERT_NOW(a_rw_apart, run_reg, idx_next != idx_reg)
    `RC5KT_ASSERT_NOW(a_pass_range, run_reg, pass_reg <= PASS_LAST)
    `RC5KT_ASSERT_NEXT(a_last_stops, run_reg && wrap && (pass_reg == PASS_LAST), !run_reg)

endmodule

// ===== sv/rc5kt_enc.sv =====
`timescale 1ns / 1ps

`include "rc5_key_trial_core_assert.svh"

module rc5kt_enc
    import rc5kt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  enc_ctl_t    enc,
    input  logic [31:0] sub_in,
    input  logic [31:0] plain_low,
    input  logic [31:0] plain_high,
    input  logic [31:0] cipher_low,
    input  logic [31:0] cipher_high,
    output logic        eval,
    output logic        match
);

    logic [31:0] ea_reg, ea_next;
    logic [31:0] eb_reg, eb_next;
    logic        eval_reg;

    // Half round per final subkey
    always_comb
    begin
        ea_next = ea_reg;
        eb_next = eb_reg;
        if (enc.load)
        begin
            if (enc.odd)
            begin
                eb_next = (enc.first ? plain_high : rotl32(eb_reg ^ ea_reg, ea_reg[4:0]))
                          + sub_in;
            end
            else
            begin
                ea_next = (enc.first ? plain_low : rotl32(ea_reg ^ eb_reg, eb_reg[4:0]))
                          + sub_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg <= ea_next;
        eb_reg <= eb_next;
    end

    // Flag the cycle after the last half round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= enc.load && enc.last;
        end
    end

    assign eval  = eval_reg;
    assign match = (ea_reg == cipher_low) && (eb_reg == cipher_high);

    `RC5KT_ASSERT_NOW(a_last_odd, enc.load && enc.last, enc.odd && !enc.first)
    `RC5KT_ASSERT_NEXT(a_eval_follows, enc.load && enc.last, eval)
    `RC5KT_ASSERT_NEXT(a_eval_single, eval, !eval)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rc5kt_pkg::*;

    localparam int NUM_ROUNDS  = ROUNDS_DEF;
    localparam int NUM_SUBKEYS = 2 * NUM_ROUNDS + 2;
    localparam int LATENCY     = 6 * NUM_ROUNDS + 8;
    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] key_low, [63:32] key_high
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] match, [7:1] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Mirror of the block registers
    logic [31:0] pt_low;
    logic [31:0] pt_high;
    logic [31:0] ct_low;
    logic [31:0] ct_high;

    // Match bits still owed by the block, oldest first
    logic        match_due[$];

    int          mismatch_count;
    int          cycle_count;
    bit          tx_steady;
    bit          rx_steady;

    rc5_key_trial_core #(
        .ROUNDS(NUM_ROUNDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Rotate left by the low five bits of the amount
    function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [31:0] amount);
        logic [4:0] s;
        s = amount[4:0];
        if (s == 5'd0)
            return x;
        return (x << s) | (x >> (6'd32 - s));
    endfunction

    // Expand the key, then encrypt one block; returns {B, A}
    function automatic logic [63:0] rc5_encrypt_block(input logic [31:0] key_lo,
                                                      input logic [31:0] key_hi,
                                                      input logic [31:0] blk_lo,
                                                      input logic [31:0] blk_hi);
        logic [31:0] subkey [0:NUM_SUBKEYS-1];
        logic [31:0] kw [0:1];
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] wa;
        logic [31:0] wb;
        int          ti;
        int          kj;
        x = 32'd0;
        y = 32'd0;
        ti = 0;
        kj = 0;
        kw[0] = key_lo;
        kw[1] = key_hi;
        subkey[0] = MAGIC_P;
        for (int k = 1; k < NUM_SUBKEYS; k++)
            subkey[k] = subkey[k-1] + MAGIC_Q;
        // Three mixing passes
        for (int k = 0; k < 3 * NUM_SUBKEYS; k++)
        begin
            x = rot_left(subkey[ti] + x + y, 32'd3);
            subkey[ti] = x;
            y = rot_left(kw[kj] + x + y, x + y);
            kw[kj] = y;
            ti = (ti + 1 == NUM_SUBKEYS) ? 0 : ti + 1;
            kj = kj ^ 1;
        end
        wa = blk_lo + subkey[0];
        wb = blk_hi + subkey[1];
        for (int r = 1; r <= NUM_ROUNDS; r++)
        begin
            wa = rot_left(wa ^ wb, wb) + subkey[2*r];
            wb = rot_left(wb ^ wa, wa) + subkey[2*r+1];
        end
        return {wb, wa};
    endfunction

    function automatic int pick_gap(input bit steady);
        if (steady || $urandom_range(3) == 0)
            return 0;
        return $urandom_range(13);
    endfunction

    // Write one register; caller keeps the block idle
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PLAIN_LOW:   pt_low  = value;
            REG_PLAIN_HIGH:  pt_high = value;
            REG_CIPHER_LOW:  ct_low  = value;
            REG_CIPHER_HIGH: ct_high = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load a plaintext and the ciphertext that the given key produces from it
    task automatic load_target(input logic [31:0] blk_lo, input logic [31:0] blk_hi,
                               input logic [63:0] key);
        logic [63:0] ct;
        ct = rc5_encrypt_block(key[31:0], key[63:32], blk_lo, blk_hi);
        write_reg(REG_PLAIN_LOW, blk_lo);
        write_reg(REG_PLAIN_HIGH, blk_hi);
        write_reg(REG_CIPHER_LOW, ct[31:0]);
        write_reg(REG_CIPHER_HIGH, ct[63:32]);
    endtask

    // Offer one key item and record its expected match bit on acceptance
    task automatic send_key(input logic [63:0] key);
        int          gap;
        logic [63:0] ct;
        gap = pick_gap(tx_steady);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        ct = rc5_encrypt_block(key[31:0], key[63:32], pt_low, pt_high);
        match_due.push_back(ct == {ct_high, ct_low});
    endtask

    // Stop sending and wait until every result is back
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (match_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver: stall a random number of cycles before each item
    initial
    begin
        int stall;
        m_tready = 1'b0;
        rx_steady = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(31) == 0)
                rx_steady = ~rx_steady;
            stall = pick_gap(rx_steady);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic report_mismatch(input string what, input logic exp_v, input logic act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s at %0t: expected %0b, got %0b", what, $time, exp_v, act_v);
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (match_due.size() == 0)
                report_mismatch("unexpected result", 1'b0, m_tdata[0]);
            else if (match_due[0] !== m_tdata[0])
                report_mismatch("match", match_due.pop_front(), m_tdata[0]);
            else
                void'(match_due.pop_front());
        end
    end

    // Key extremes against the reset registers
    task automatic test_key_extremes;
        send_key(64'h0000_0000_0000_0000);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'hFFFF_FFFF_0000_0000);
        send_key(64'h0000_0000_FFFF_FFFF);
        send_key(64'h5555_5555_AAAA_AAAA);
        send_key(64'h0000_0000_0000_0001);
        drain();
    endtask

    // A planted key must hit, its neighbors must miss
    task automatic test_planted_key;
        logic [63:0] key;
        key = 64'h0123_4567_89AB_CDEF;
        load_target(32'hDEAD_BEEF, 32'h1234_5678, key);
        send_key(key);
        send_key(key ^ 64'h1);
        send_key(key ^ 64'h8000_0000_0000_0000);
        send_key(key);
        drain();
    endtask

    // Both ciphertext words right: match; only one word right: no match
    task automatic test_half_match;
        logic [63:0] key;
        key = 64'hFEDC_BA98_7654_3210;
        load_target(32'h0000_0000, 32'hFFFF_FFFF, key);
        send_key(key);
        drain();
        write_reg(REG_CIPHER_HIGH, ~ct_high);
        send_key(key);
        drain();
        load_target(32'h0000_0000, 32'hFFFF_FFFF, key);
        write_reg(REG_CIPHER_LOW, ~ct_low);
        send_key(key);
        drain();
    endtask

    // Register extremes: all-zero and all-one plaintexts, all-one target
    task automatic test_register_extremes;
        load_target(32'h0000_0000, 32'h0000_0000, 64'h0);
        send_key(64'h0);
        drain();
        load_target(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        write_reg(REG_CIPHER_LOW, 32'hFFFF_FFFF);
        write_reg(REG_CIPHER_HIGH, 32'hFFFF_FFFF);
        send_key(64'h0);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        drain();
    endtask

    // Phases of planted keys, near misses and random keys
    task automatic test_random_keys;
        logic [63:0] target;
        logic [31:0] blk_lo;
        logic [31:0] blk_hi;
        int          pick;
        for (int phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(3))
                0:       blk_lo = 32'h0000_0000;
                1:       blk_lo = 32'hFFFF_FFFF;
                default: blk_lo = $urandom;
            endcase
            case ($urandom_range(3))
                0:       blk_hi = 32'h0000_0000;
                1:       blk_hi = 32'hFFFF_FFFF;
                default: blk_hi = $urandom;
            endcase
            target = {$urandom, $urandom};
            load_target(blk_lo, blk_hi, target);
            if (phase % 4 == 3)
            begin
                write_reg(REG_CIPHER_LOW, $urandom);
                write_reg(REG_CIPHER_HIGH, $urandom);
            end
            tx_steady = (phase % 3 == 1);
            for (int n = 0; n < 100; n++)
            begin
                // Hold off once mid-phase until the block has caught up
                if (phase == 5 && n == 50)
                    drain();
                pick = $urandom_range(99);
                if (pick < 15)
                    send_key(target);
                else if (pick < 35)
                    send_key(target ^ (64'h1 << $urandom_range(63)));
                else
                    send_key({$urandom, $urandom});
            end
            drain();
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_PLAIN_LOW;
        cfg_data = 32'd0;
        pt_low = 32'd0;
        pt_high = 32'd0;
        ct_low = 32'd0;
        ct_high = 32'd0;
        mismatch_count = 0;
        cycle_count = 0;
        tx_steady = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_key_extremes();
        test_planted_key();
        test_half_match();
        test_register_extremes();
        test_random_keys();

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && match_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
